// ===== design/cfe_pkg.sv =====
// ----------------------------------------------------------------------------
// cfe_pkg
// Shared types and character constants for the CSV field extractor.
// ----------------------------------------------------------------------------
`default_nettype none

package cfe_pkg;

	localparam int unsigned MAX_FIELDS = 255;
	localparam int unsigned FIELD_W    = 8;

	localparam logic [7:0] CH_SEP   = 8'h2C;
	localparam logic [7:0] CH_QUOTE = 8'h22;
	localparam logic [7:0] CH_NUL   = 8'h00;

	typedef enum logic [1:0] {
		MODE_START  = 2'd0,
		MODE_PLAIN  = 2'd1,
		MODE_QUOTED = 2'd2,
		MODE_QSEEN  = 2'd3
	} parse_mode_t;

	typedef struct packed {
		logic [7:0] in_byte;
		logic       line_end;
	} cfe_in_t;

	typedef struct packed {
		logic       byte_valid;
		logic [7:0] out_byte;
		logic       field_done;
		logic       field_reached;
	} cfe_out_t;

endpackage

`default_nettype wire

// ===== design/cfe_in_stage.sv =====
// ----------------------------------------------------------------------------
// cfe_in_stage
// Input register: captures one byte transaction and holds it until the
// parser hands its result on.
// ----------------------------------------------------------------------------
`default_nettype none

module cfe_in_stage (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            in_valid,
	output logic                 in_ready,
	input  wire cfe_pkg::cfe_in_t in_data,
	input  wire logic            advance,
	output logic                 valid_s1,
	output cfe_pkg::cfe_in_t     data_s1
);
	import cfe_pkg::*;

	assign in_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			data_s1 <= in_data;
		end
	end

endmodule

`default_nettype wire

// ===== design/cfe_parser.sv =====
// ----------------------------------------------------------------------------
// cfe_parser
// Line parse state and the per-byte decision: field counting, quote
// handling and the completion report for the selected field.
// ----------------------------------------------------------------------------
`default_nettype none

module cfe_parser (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire cfe_pkg::cfe_in_t              item,
	input  wire logic                          advance,
	input  wire logic [cfe_pkg::FIELD_W-1:0]   field_index,
	output logic                               res_valid,
	output cfe_pkg::cfe_out_t                  res
);
	import cfe_pkg::*;

	parse_mode_t        mode_q, mode_n;
	logic [FIELD_W-1:0] field_q, field_n;
	logic               done_sent_q, done_sent_n;
	logic               term_q, term_n;

	logic [FIELD_W-1:0] target;
	logic               sel;
	logic               bv, done, reached, nf;
	logic [7:0]         ob;
	logic               last;
	logic [7:0]         b;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q      <= MODE_START;
			field_q     <= FIELD_W'(1);
			done_sent_q <= 1'b0;
			term_q      <= 1'b0;
		end else if (advance) begin
			mode_q      <= mode_n;
			field_q     <= field_n;
			done_sent_q <= done_sent_n;
			term_q      <= term_n;
		end
	end

	always_comb begin
		b       = item.in_byte;
		last    = item.line_end;
		target  = (field_index == '0) ? FIELD_W'(1) : field_index;
		sel     = (field_q == target);
		bv      = 1'b0;
		ob      = 8'h00;
		done    = 1'b0;
		reached = 1'b0;
		nf      = 1'b0;
		mode_n  = mode_q;
		field_n = field_q;
		term_n  = term_q;

		if (!done_sent_q && !term_q) begin
			if (b == CH_NUL) begin
				done    = 1'b1;
				reached = sel;
				term_n  = 1'b1;
			end else if (sel) begin
				unique case (mode_q)
					MODE_START: begin
						if (b == CH_SEP) begin
							done = 1'b1;
						end else if (b == CH_QUOTE) begin
							mode_n = MODE_QUOTED;
						end else begin
							bv     = 1'b1;
							ob     = b;
							mode_n = MODE_PLAIN;
						end
					end
					MODE_PLAIN: begin
						if (b == CH_SEP) begin
							done = 1'b1;
						end else begin
							bv = 1'b1;
							ob = b;
						end
					end
					MODE_QUOTED: begin
						if (b == CH_QUOTE) begin
							mode_n = MODE_QSEEN;
						end else begin
							bv = 1'b1;
							ob = b;
						end
					end
					MODE_QSEEN: begin
						// doubled quote gives one quote, anything else closes the field
						if (b == CH_QUOTE) begin
							bv     = 1'b1;
							ob     = b;
							mode_n = MODE_QUOTED;
						end else begin
							done = 1'b1;
						end
					end
				endcase
				reached = done;
			end else begin
				unique case (mode_q)
					MODE_START: begin
						if (b == CH_SEP) begin
							nf = 1'b1;
						end else if (b == CH_QUOTE) begin
							mode_n = MODE_QUOTED;
						end else begin
							mode_n = MODE_PLAIN;
						end
					end
					MODE_PLAIN: begin
						nf = (b == CH_SEP);
					end
					MODE_QUOTED: begin
						if (b == CH_QUOTE) begin
							mode_n = MODE_QSEEN;
						end
					end
					MODE_QSEEN: begin
						// byte after the closing quote counts as the separator
						if (b == CH_QUOTE) begin
							mode_n = MODE_QUOTED;
						end else begin
							nf = 1'b1;
						end
					end
				endcase
				if (nf) begin
					mode_n = MODE_START;
					if (32'(field_q) < MAX_FIELDS) begin
						field_n = field_q + FIELD_W'(1);
					end
				end
			end

			// line end closes the report with the updated field count
			if (!done && last) begin
				done    = 1'b1;
				reached = (field_n == target);
			end
		end

		done_sent_n = done_sent_q || done;

		if (last) begin
			mode_n      = MODE_START;
			field_n     = FIELD_W'(1);
			done_sent_n = 1'b0;
			term_n      = 1'b0;
		end

		res_valid         = bv || done;
		res.byte_valid    = bv;
		res.out_byte      = ob;
		res.field_done    = done;
		res.field_reached = done && reached;
	end

endmodule

`default_nettype wire

// ===== design/cfe_out_stage.sv =====
// ----------------------------------------------------------------------------
// cfe_out_stage
// Result register: holds one result transaction until the sink takes it.
// ----------------------------------------------------------------------------
`default_nettype none

module cfe_out_stage (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              valid_s1,
	input  wire logic              res_valid,
	input  wire cfe_pkg::cfe_out_t res,
	output logic                   advance,
	output logic                   out_valid,
	input  wire logic              out_ready,
	output cfe_pkg::cfe_out_t      out_data
);
	import cfe_pkg::*;

	logic load;

	assign load    = !out_valid || out_ready;
	assign advance = valid_s1 && load;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (load) begin
			out_valid <= valid_s1 && res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && res_valid) begin
			out_data <= res;
		end
	end

endmodule

`default_nettype wire

// ===== design/csv_field_extractor_unit.sv =====
// ----------------------------------------------------------------------------
// csv_field_extractor_unit
// Streams one CSV line byte by byte and returns the unescaped content of
// the selected field, followed by a completion report.
// ----------------------------------------------------------------------------
//  channel  | direction | handshake            | payload
//  in       | sink      | in_valid / in_ready   | cfe_in_t  (in_byte, line_end)
//  out      | source    | out_valid / out_ready | cfe_out_t (byte_valid .. field_reached)
//  cfg      | sink      | cfg_we               | cfg_wdata = field_index
//
// one byte per cycle sustained while the sink takes every result; a byte taken
// passes from the input register through the parse logic into the result register
// bytes that produce no result never reach the output register
// reset clears the line state and sets field_index to 1
// a stalled output holds its result; the input register still drains
// into it in the cycle the sink takes the result
// ----------------------------------------------------------------------------
`default_nettype none

module csv_field_extractor_unit (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        in_valid,
	output logic                             in_ready,
	input  wire cfe_pkg::cfe_in_t            in_data,
	output logic                             out_valid,
	input  wire logic                        out_ready,
	output cfe_pkg::cfe_out_t                out_data,
	input  wire logic                        cfg_we,
	input  wire logic [cfe_pkg::FIELD_W-1:0] cfg_wdata
);
	import cfe_pkg::*;

	logic [FIELD_W-1:0] field_index_q;
	logic               valid_s1;
	cfe_in_t            data_s1;
	logic               advance;
	logic               res_valid;
	cfe_out_t           res;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			field_index_q <= FIELD_W'(1);
		end else if (cfg_we) begin
			field_index_q <= cfg_wdata;
		end
	end

	cfe_in_stage u_in (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_data  (in_data),
		.advance  (advance),
		.valid_s1 (valid_s1),
		.data_s1  (data_s1)
	);

	cfe_parser u_parser (
		.clk         (clk),
		.arst_n      (arst_n),
		.item        (data_s1),
		.advance     (advance),
		.field_index (field_index_q),
		.res_valid   (res_valid),
		.res         (res)
	);

	cfe_out_stage u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.valid_s1  (valid_s1),
		.res_valid (res_valid),
		.res       (res),
		.advance   (advance),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

endmodule

`default_nettype wire

// ===== design/cfe_checker.sv =====
// ----------------------------------------------------------------------------
// cfe_checker
// Port-level checks on the result channel of the CSV field extractor.
// ----------------------------------------------------------------------------
`default_nettype none

module cfe_checker (
	input wire logic                        clk,
	input wire logic                        arst_n,
	input wire logic                        in_valid,
	input wire logic                        in_ready,
	input wire cfe_pkg::cfe_in_t            in_data,
	input wire logic                        out_valid,
	input wire logic                        out_ready,
	input wire cfe_pkg::cfe_out_t           out_data,
	input wire logic                        cfg_we,
	input wire logic [cfe_pkg::FIELD_W-1:0] cfg_wdata
);
	import cfe_pkg::*;

	// a stalled result transaction holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("result changed while stalled");

	// every result carries a byte or a completion
	a_no_empty: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> out_data.byte_valid || out_data.field_done)
		else $error("empty result");

	a_byte_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_data.byte_valid |-> out_data.out_byte == 8'h00)
		else $error("out_byte set without byte_valid");

	a_reached: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_data.field_done |-> !out_data.field_reached)
		else $error("field_reached without field_done");

	// an idle input and an empty result register that stays empty cannot be followed by a result
	a_no_invent: assert property (@(posedge clk) disable iff (!arst_n)
		!(in_valid && in_ready) && !out_valid ##1 !out_valid
			|=> !out_valid)
		else $error("result without a byte");

endmodule

bind csv_field_extractor_unit cfe_checker u_cfe_checker (.*);

`default_nettype wire

// ===== tb/csv_field_extractor_unit_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// csv_field_extractor_unit_tb
// Sends CSV lines byte by byte through the extractor under random source
// gaps and sink stalls, predicts the extracted field content and completion
// reports, and checks every result transaction against the prediction.
// ----------------------------------------------------------------------------

module csv_field_extractor_unit_tb;
	import cfe_pkg::*;

	localparam int unsigned CYCLE_LIMIT  = 400000;
	localparam int unsigned RANDOM_ITEMS = 1200;
	localparam int unsigned SETTLE_CYCLES = 8;
	localparam int unsigned LONG_HOLD    = 150;
	localparam logic [7:0]  EARLY_INDEX [7] = '{8'd1, 8'd255, 8'd2, 8'd0, 8'd3, 8'd254, 8'd1};

	typedef logic [7:0] byte_q_t [$];

	typedef enum {RX_ALWAYS, RX_COIN, RX_EVERY_FOURTH, RX_MOSTLY} rx_style_e;
	typedef enum {FK_EMPTY, FK_PLAIN, FK_QUOTED, FK_BROKEN, FK_NOISE} field_kind_e;

	// tracks the line parse and holds the field results still owed by the dut
	class field_tracker;
		logic [7:0]  selected_field;
		parse_mode_t mode;
		logic [7:0]  field_no;
		bit          reported;
		bit          cut_short;
		cfe_out_t    field_results_due [$];
		int unsigned mismatches;

		function new();
			selected_field = 8'd1;
			mismatches = 0;
			restart_line();
		endfunction

		function void restart_line();
			mode = MODE_START;
			field_no = 8'd1;
			reported = 1'b0;
			cut_short = 1'b0;
		endfunction

		function void skip_field();
			mode = MODE_START;
			if (field_no < MAX_FIELDS)
				field_no++;
		endfunction

		// returns 1 when the byte was parsed rather than dropped
		function bit take_byte(cfe_in_t item);
			logic [7:0] b;
			logic [7:0] target;
			logic [7:0] ob;
			bit bv, done, reached, sel, live;
			cfe_out_t r;
			b = item.in_byte;
			target = (selected_field == 8'd0) ? 8'd1 : selected_field;
			bv = 1'b0;
			done = 1'b0;
			reached = 1'b0;
			ob = 8'd0;
			live = !reported && !cut_short;
			if (live) begin
				sel = (field_no == target);
				if (b == CH_NUL) begin
					done = 1'b1;
					reached = sel;
					cut_short = 1'b1;
				end else if (sel) begin
					case (mode)
						MODE_START: begin
							if (b == CH_SEP) done = 1'b1;
							else if (b == CH_QUOTE) mode = MODE_QUOTED;
							else begin
								bv = 1'b1;
								ob = b;
								mode = MODE_PLAIN;
							end
						end
						MODE_PLAIN: begin
							if (b == CH_SEP) done = 1'b1;
							else begin
								bv = 1'b1;
								ob = b;
							end
						end
						MODE_QUOTED: begin
							if (b == CH_QUOTE) mode = MODE_QSEEN;
							else begin
								bv = 1'b1;
								ob = b;
							end
						end
						default: begin
							// doubled quote gives one quote, anything else closes the field
							if (b == CH_QUOTE) begin
								bv = 1'b1;
								ob = b;
								mode = MODE_QUOTED;
							end else done = 1'b1;
						end
					endcase
					if (done)
						reached = 1'b1;
				end else begin
					case (mode)
						MODE_START: begin
							if (b == CH_SEP) skip_field();
							else if (b == CH_QUOTE) mode = MODE_QUOTED;
							else mode = MODE_PLAIN;
						end
						MODE_PLAIN: begin
							if (b == CH_SEP) skip_field();
						end
						MODE_QUOTED: begin
							if (b == CH_QUOTE) mode = MODE_QSEEN;
						end
						default: begin
							if (b == CH_QUOTE) mode = MODE_QUOTED;
							else skip_field();
						end
					endcase
				end
				if (!done && item.line_end) begin
					done = 1'b1;
					reached = (field_no == target);
				end
				if (done)
					reported = 1'b1;
			end
			if (item.line_end)
				restart_line();
			if (bv || done) begin
				r.byte_valid = bv;
				r.out_byte = bv ? ob : 8'd0;
				r.field_done = done;
				r.field_reached = done && reached;
				field_results_due.push_back(r);
			end
			return live;
		endfunction

		function void check_field_result(cfe_out_t got);
			cfe_out_t want;
			if (field_results_due.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result: bv=%0b byte=%02h done=%0b reached=%0b",
						got.byte_valid, got.out_byte, got.field_done, got.field_reached);
				return;
			end
			want = field_results_due.pop_front();
			if (got.byte_valid !== want.byte_valid || got.out_byte !== want.out_byte ||
					got.field_done !== want.field_done ||
					got.field_reached !== want.field_reached) begin
				mismatches++;
				if (mismatches <= 10)
					$display({"result mismatch: expected bv=%0b byte=%02h done=%0b reached=%0b,",
						" got bv=%0b byte=%02h done=%0b reached=%0b"},
						want.byte_valid, want.out_byte, want.field_done, want.field_reached,
						got.byte_valid, got.out_byte, got.field_done, got.field_reached);
			end
		endfunction
	endclass

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                in_valid = 1'b0;
	logic                in_ready;
	cfe_in_t             in_data = '0;
	logic                out_valid;
	logic                out_ready = 1'b0;
	cfe_out_t            out_data;
	logic                cfg_we = 1'b0;
	logic [FIELD_W-1:0]  cfg_wdata = 8'd1;

	field_tracker tracker = new();
	int unsigned  cycle_count = 0;
	int unsigned  live_items = 0;
	int unsigned  burst_left = 0;
	int unsigned  gap_max = 0;
	int unsigned  hold_cycles = 0;
	int unsigned  rx_tick = 0;
	rx_style_e    rx_style = RX_ALWAYS;

	csv_field_extractor_unit dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("Mismatches found");
			$finish;
		end
	end

	// result side: check every transaction taken at a rising edge
	initial begin
		forever begin
			@(posedge clk);
			if (arst_n && out_valid && out_ready)
				tracker.check_field_result(out_data);
		end
	end

	// sink stall pattern, with an occasional long hold-off
	initial begin
		forever begin
			@(negedge clk);
			rx_tick++;
			if (rx_tick % 97 == 0)
				rx_style = rx_style_e'($urandom_range(0, 3));
			if (hold_cycles > 0) begin
				hold_cycles--;
				out_ready <= 1'b0;
			end else begin
				case (rx_style)
					RX_ALWAYS:       out_ready <= 1'b1;
					RX_COIN:         out_ready <= 1'($urandom_range(0, 1));
					RX_EVERY_FOURTH: out_ready <= (rx_tick % 4 == 0);
					default:         out_ready <= ($urandom_range(0, 9) != 0);
				endcase
			end
		end
	end

	task automatic send_byte(input logic [7:0] b, input bit last);
		cfe_in_t item;
		int unsigned gap;
		if (burst_left == 0) begin
			if (gap_max > 0) begin
				gap = $urandom_range(1, gap_max);
				@(negedge clk);
				in_valid <= 1'b0;
				repeat (gap - 1) @(negedge clk);
			end
			burst_left = $urandom_range(1, 40);
		end
		burst_left--;
		item.in_byte = b;
		item.line_end = last;
		@(negedge clk);
		in_valid <= 1'b1;
		in_data <= item;
		do @(posedge clk); while (!in_ready);
		void'(tracker.take_byte(item));
		live_items++;
	endtask

	task automatic send_line(input byte_q_t bytes);
		foreach (bytes[i])
			send_byte(bytes[i], i == bytes.size() - 1);
	endtask

	task automatic send_text(input string s);
		byte_q_t bytes;
		for (int i = 0; i < s.len(); i++)
			bytes.push_back(s[i]);
		send_line(bytes);
	endtask

	// wait for every owed result, then for bytes that never give one to clear
	task automatic settle();
		@(negedge clk);
		in_valid <= 1'b0;
		while (tracker.field_results_due.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic set_field_index(input logic [7:0] v);
		settle();
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		tracker.selected_field = v;
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	function automatic field_kind_e pick_kind();
		int unsigned r;
		r = $urandom_range(0, 9);
		if (r == 0) return FK_EMPTY;
		if (r <= 4) return FK_PLAIN;
		if (r <= 7) return FK_QUOTED;
		if (r == 8) return FK_BROKEN;
		return FK_NOISE;
	endfunction

	function automatic byte_q_t make_random_line(input logic [7:0] target, input bit reach);
		byte_q_t q;
		int unsigned nfields;
		int unsigned len;
		bit sparse;
		bit last_field;
		logic [7:0] c;
		field_kind_e kind;
		if (target > 12 && reach)
			nfields = target + $urandom_range(0, 4) - 2;
		else
			nfields = $urandom_range(1, 8);
		sparse = (nfields > 20);
		for (int f = 0; f < nfields; f++) begin
			last_field = (f == nfields - 1);
			kind = (sparse && $urandom_range(0, 9) != 0) ? FK_EMPTY : pick_kind();
			case (kind)
				FK_PLAIN: begin
					len = $urandom_range(1, 6);
					for (int i = 0; i < len; i++) begin
						c = 8'($urandom_range(1, 255));
						if (c == CH_SEP || (i == 0 && c == CH_QUOTE))
							c = 8'h5F;
						else if ($urandom_range(0, 7) == 0 && i != 0)
							c = CH_QUOTE;
						q.push_back(c);
					end
				end
				FK_QUOTED: begin
					q.push_back(CH_QUOTE);
					len = $urandom_range(0, 6);
					for (int i = 0; i < len; i++) begin
						c = ($urandom_range(0, 4) == 0) ? CH_QUOTE : 8'($urandom_range(1, 255));
						q.push_back(c);
						if (c == CH_QUOTE)
							q.push_back(c);
					end
					q.push_back(CH_QUOTE);
					// any byte after the closing quote acts as the separator
					if ($urandom_range(0, 3) == 0) begin
						c = 8'($urandom_range(1, 255));
						if (c == CH_QUOTE)
							c = 8'h3B;
						q.push_back(c);
						if (last_field)
							q.push_back(8'($urandom_range(1, 255)));
						continue;
					end
				end
				FK_BROKEN: begin
					q.push_back(CH_QUOTE);
					len = $urandom_range(0, 5);
					for (int i = 0; i < len; i++)
						q.push_back(($urandom_range(0, 2) == 0) ? CH_QUOTE :
							8'($urandom_range(1, 255)));
				end
				FK_NOISE: begin
					len = $urandom_range(1, 4);
					for (int i = 0; i < len; i++)
						q.push_back(8'($urandom_range(0, 255)));
				end
				default: ;
			endcase
			if (!last_field)
				q.push_back(CH_SEP);
		end
		if ($urandom_range(0, 19) == 0) begin
			q.delete();
			len = $urandom_range(1, 12);
			for (int i = 0; i < len; i++)
				q.push_back(8'($urandom_range(0, 255)));
		end
		if (q.size() == 0)
			q.push_back(8'h61);
		if ($urandom_range(0, 29) == 0)
			q[$urandom_range(0, q.size() - 1)] = CH_NUL;
		return q;
	endfunction

	initial begin
		logic [7:0] idx;
		int unsigned phase_no;
		int unsigned lines;
		int unsigned r;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// directed lines at the reset field index, then at field indices 0, 255 and 2
		gap_max = 0;
		send_text("\"a\"\"b\"x,c");
		send_text(",");
		send_text("a\"b");
		send_line('{8'hFF, CH_NUL, 8'h41});
		set_field_index(8'd0);
		send_text("x");
		set_field_index(8'd255);
		send_text("a,b");
		set_field_index(8'd2);
		send_text("p,\"\",q");

		live_items = 0;
		phase_no = 0;
		while (live_items < RANDOM_ITEMS) begin
			if (phase_no < 7) idx = EARLY_INDEX[phase_no];
			else begin
				r = $urandom_range(0, 19);
				if (r < 14) idx = 8'($urandom_range(1, 5));
				else if (r < 16) idx = 8'($urandom_range(6, 12));
				else if (r < 18) idx = 8'd0;
				else idx = 8'($urandom_range(250, 255));
			end
			set_field_index(idx);
			gap_max = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 10);
			lines = (idx > 12) ? 2 : $urandom_range(4, 12);
			for (int n = 0; n < lines; n++) begin
				if (live_items >= RANDOM_ITEMS)
					break;
				// long sink hold-off while the source keeps pushing
				if (n == 1 && (phase_no == 2 || phase_no == 6))
					hold_cycles = LONG_HOLD;
				send_line(make_random_line(idx, n == 0));
			end
			phase_no++;
		end

		settle();
		if (tracker.mismatches == 0 && tracker.field_results_due.size() == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule
